>>> rtl/core/agpw_pkg.sv
package agpw_pkg;

  localparam int MaxScaleDef = 8;

  localparam int TdataInW  = 96;
  localparam int TdataOutW = 56;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 13;
  localparam int DimW      = 13;
  localparam int ScaleW    = 4;
  localparam int CoordW    = 12;
  localparam int ChanW     = 24;
  localparam int IndexW    = 24;

  typedef enum logic [CfgAddrW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgScaleFactor = 2'd2
  } cfg_reg_e;

  // floor(n/255) = (n * RecipDiv255) >> RecipShift for n < 2^23
  localparam logic [23:0] RecipDiv255 = 24'd8421505;
  localparam int          RecipShift  = 31;
  localparam int          XW          = 20;
  localparam logic [XW-1:0] XSat      = 20'd524288;

  // curve coefficients, scaled by 100
  localparam logic [7:0] AcesA = 8'd251;
  localparam logic [7:0] AcesB = 8'd3;
  localparam logic [7:0] AcesC = 8'd243;
  localparam logic [7:0] AcesD = 8'd59;
  localparam logic [7:0] AcesE = 8'd14;

  localparam int SqW      = 2 * XW;
  localparam int NumW     = 46;
  localparam int DenW     = 46;
  localparam int RemW     = 63;
  localparam int QuoW     = 17;
  localparam int DivSteps = QuoW;
  localparam int GamSteps = 8;
  localparam int ToneLat  = 4 + DivSteps + GamSteps;

  typedef logic [255:0][QuoW-1:0] thr_tab_t;

  // Smallest t with (v/255)^2.2 <= t/65536, tested as v^11 * 2^80 <= t^5 * 255^11
  function automatic thr_tab_t gamma_thr_gen();
    thr_tab_t     tab;
    logic [199:0] p255;
    logic [199:0] lhs;
    logic [199:0] rhs;
    int           lo;
    int           hi;
    int           mid;
    p255 = 200'd1;
    for (int k = 0; k < 11; k++) p255 = p255 * 200'd255;
    tab = '0;
    for (int v = 1; v < 256; v++) begin
      lhs = 200'd1;
      for (int k = 0; k < 11; k++) lhs = lhs * 200'(v);
      lhs = lhs << 80;
      lo = 0;
      hi = 65536;
      for (int it = 0; it < 18; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          rhs = 200'd1;
          for (int k = 0; k < 5; k++) rhs = rhs * 200'(mid);
          rhs = rhs * p255;
          if (rhs >= lhs) hi = mid;
          else lo = mid + 1;
        end
      end
      tab[v] = QuoW'(lo);
    end
    return tab;
  endfunction

  localparam thr_tab_t GammaThr = gamma_thr_gen();

endpackage

>>> rtl/core/agpw_tone.sv
module agpw_tone import agpw_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ChanW-1:0] raw_i,
  output logic [7:0]       byte_o
);

  logic [46:0]     s1_prod_q;
  logic [22:0]     s1_raw_q;
  logic            s1_pos_q;
  logic [23:0]     s2_sum;
  logic [XW-1:0]   s2_x_q;
  logic [SqW-1:0]  s3_sq_q;
  logic [XW-1:0]   s3_x_q;
  logic [NumW-1:0] s4_num_q;
  logic [DenW-1:0] s4_den_q;

  logic [RemW-1:0] dv_rem_q [DivSteps];
  logic [DenW-1:0] dv_den_q [DivSteps];
  logic [QuoW-1:0] dv_quo_q [DivSteps];

  logic [QuoW-1:0] gm_t_q [GamSteps];
  logic [7:0]      gm_v_q [GamSteps];

  assign s2_sum = 24'(s1_raw_q) + 24'(s1_prod_q >> RecipShift);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_prod_q <= 47'(raw_i[22:0]) * 47'(RecipDiv255);
      s1_raw_q  <= raw_i[22:0];
      s1_pos_q  <= !raw_i[ChanW-1] && (raw_i != '0);
      // a non-positive channel enters the curve as zero and leaves as byte 0
      if (!s1_pos_q) begin
        s2_x_q <= '0;
      end else if (s2_sum > 24'(XSat)) begin
        s2_x_q <= XSat;
      end else begin
        s2_x_q <= s2_sum[XW-1:0];
      end
      s3_sq_q  <= SqW'(s2_x_q) * SqW'(s2_x_q);
      s3_x_q   <= s2_x_q;
      s4_num_q <= NumW'(s3_sq_q) * NumW'(AcesA) + ((NumW'(s3_x_q) * NumW'(AcesB)) << 16);
      s4_den_q <= DenW'(s3_sq_q) * DenW'(AcesC) + ((DenW'(s3_x_q) * DenW'(AcesD)) << 16)
                  + (DenW'(AcesE) << 32);
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [RemW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [RemW-1:0] shifted;
    if (k == 0) begin : g_first
      assign rem_in = RemW'({s4_num_q, 16'b0});
      assign den_in = s4_den_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = dv_rem_q[k-1];
      assign den_in = dv_den_q[k-1];
      assign quo_in = dv_quo_q[k-1];
    end
    assign shifted = RemW'(den_in) << (QuoW - 1 - k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_den_q[k] <= den_in;
        if (rem_in >= shifted) begin
          dv_rem_q[k] <= rem_in - shifted;
          dv_quo_q[k] <= quo_in | (QuoW'(1) << (QuoW - 1 - k));
        end else begin
          dv_rem_q[k] <= rem_in;
          dv_quo_q[k] <= quo_in;
        end
      end
    end
  end

  // binary search of the gamma threshold table, one byte bit per stage
  for (genvar k = 0; k < GamSteps; k++) begin : g_gam
    logic [QuoW-1:0] t_in;
    logic [7:0]      v_in;
    logic [7:0]      cand;
    if (k == 0) begin : g_first
      assign t_in = dv_quo_q[DivSteps-1];
      assign v_in = '0;
    end else begin : g_next
      assign t_in = gm_t_q[k-1];
      assign v_in = gm_v_q[k-1];
    end
    assign cand = v_in | (8'd1 << (GamSteps - 1 - k));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        gm_t_q[k] <= t_in;
        gm_v_q[k] <= (GammaThr[cand] <= t_in) ? cand : v_in;
      end
    end
  end

  assign byte_o = gm_v_q[GamSteps-1];

endmodule

>>> rtl/core/aces_gamma_pixel_writer_core.sv
// Tone-mapping pixel writer.
// Input stream s_axis_*: one HDR pixel per request (column, row, signed Q16.8
// red, green, blue). Each channel goes through the ACES filmic curve and gamma
// 1/2.2 to a byte. Output stream m_axis_*: one framebuffer write per cell of a
// scale_factor x scale_factor block, column offset outer, row offset inner,
// rows flipped against frame_height; tlast marks the final write of a block.
// Writes outside the frame come with in_frame low and index zero.
// Configuration channel cfg_*: register index and data, always ready; write
// only while the block is idle. Scale 0 drops the pixel.
// Path of an accepted request to its first write: the 29-stage tone pipeline
// (4 arithmetic stages, 17 divider stages, 8 gamma search stages), then the
// block expander and the address multiplier.
// Throughput: one pixel per cycle at scale 1 unless stalled; at larger scales
// one write per cycle unless stalled; the next pixel enters on a last write.
// Reset clears all valid bits and loads 640 x 480, scale 1.
// A stall on m_axis_tready holds the output register and backs up the whole
// pipeline; s_axis_tready is low while the expander cannot release its pixel.
module aces_gamma_pixel_writer_core import agpw_pkg::*; #(
  parameter int MaxScale = MaxScaleDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // column[11:0], row[23:12], red_in[47:24], green_in[71:48], blue_in[95:72]
  input  logic [TdataInW-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_index[23:0], blue_out[31:24], green_out[39:32], red_out[47:40],
  // in_frame[48], zero[55:49]
  output logic [TdataOutW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CntW = $clog2(MaxScale + 1);
  localparam int SclW = (CntW > ScaleW) ? CntW : ScaleW;

  logic [DimW-1:0]   fw_q, fh_q;
  logic [ScaleW-1:0] sc_q;
  logic [SclW-1:0]   sc_ext;
  logic [CntW-1:0]   s_sat;

  logic en_tone, en_post;

  logic              vld_q [ToneLat];
  logic [CoordW-1:0] col_q [ToneLat];
  logic [CoordW-1:0] row_q [ToneLat];
  logic [7:0]        red_b, green_b, blue_b;

  logic              gen_full_q;
  logic [CoordW-1:0] gen_x_q, gen_y_q;
  logic [7:0]        gen_r_q, gen_g_q, gen_b_q;
  logic [CntW-1:0]   gen_i_q, gen_j_q, gen_s_q;
  logic              gen_last;

  logic              p1_vld_q;
  logic [14:0]       p1_ry_q;
  logic [DimW-1:0]   p1_cx_q;
  logic [7:0]        p1_r_q, p1_g_q, p1_b_q;
  logic              p1_last_q;
  logic              p1_inside;
  logic [25:0]       p1_idx;

  logic              out_vld_q;
  logic [IndexW-1:0] out_idx_q;
  logic [7:0]        out_r_q, out_g_q, out_b_q;
  logic              out_in_q, out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 13'd640;
      fh_q <= 13'd480;
      sc_q <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CfgFrameWidth:  fw_q <= cfg_data_i;
        CfgFrameHeight: fh_q <= cfg_data_i;
        CfgScaleFactor: sc_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign sc_ext = SclW'(sc_q);
  assign s_sat  = (sc_ext > SclW'(MaxScale)) ? CntW'(MaxScale) : CntW'(sc_ext);

  assign gen_last = (gen_i_q == gen_s_q - CntW'(1)) && (gen_j_q == gen_s_q - CntW'(1));
  assign en_post  = !out_vld_q || m_axis_tready;
  assign en_tone  = !gen_full_q || (en_post && gen_last);
  assign s_axis_tready = en_tone;

  // tone pipeline, one instance per channel
  agpw_tone u_red (
    .clk_i  (clk_i),
    .en_i   (en_tone),
    .raw_i  (s_axis_tdata[47:24]),
    .byte_o (red_b)
  );
  agpw_tone u_green (
    .clk_i  (clk_i),
    .en_i   (en_tone),
    .raw_i  (s_axis_tdata[71:48]),
    .byte_o (green_b)
  );
  agpw_tone u_blue (
    .clk_i  (clk_i),
    .en_i   (en_tone),
    .raw_i  (s_axis_tdata[95:72]),
    .byte_o (blue_b)
  );

  for (genvar k = 0; k < ToneLat; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_tone) begin
        vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_tone) begin
        if (k == 0) begin
          col_q[k] <= s_axis_tdata[11:0];
          row_q[k] <= s_axis_tdata[23:12];
        end else begin
          col_q[k] <= col_q[(k == 0) ? 0 : k - 1];
          row_q[k] <= row_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // block expander: hold one pixel, step row offset fastest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_full_q <= 1'b0;
      gen_i_q    <= '0;
      gen_j_q    <= '0;
      gen_s_q    <= '0;
    end else if (en_tone) begin
      gen_full_q <= vld_q[ToneLat-1] && (s_sat != '0);
      gen_i_q    <= '0;
      gen_j_q    <= '0;
      gen_s_q    <= s_sat;
    end else if (en_post && gen_full_q) begin
      if (gen_j_q == gen_s_q - CntW'(1)) begin
        gen_j_q <= '0;
        gen_i_q <= gen_i_q + CntW'(1);
      end else begin
        gen_j_q <= gen_j_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_tone) begin
      gen_x_q <= col_q[ToneLat-1];
      gen_y_q <= row_q[ToneLat-1];
      gen_r_q <= red_b;
      gen_g_q <= green_b;
      gen_b_q <= blue_b;
    end
  end

  // address stage: flipped row and column of the cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_post) begin
      p1_vld_q  <= gen_full_q;
      out_vld_q <= p1_vld_q;
    end
  end

  assign p1_inside = !p1_ry_q[14] && (p1_cx_q < fw_q);
  assign p1_idx    = 26'(p1_ry_q[DimW-1:0]) * 26'(fw_q) + 26'(p1_cx_q);

  always_ff @(posedge clk_i) begin
    if (en_post) begin
      p1_ry_q    <= 15'(fh_q) - 15'd1 - 15'(gen_y_q) - 15'(gen_j_q);
      p1_cx_q    <= DimW'(gen_x_q) + DimW'(gen_i_q);
      p1_r_q     <= gen_r_q;
      p1_g_q     <= gen_g_q;
      p1_b_q     <= gen_b_q;
      p1_last_q  <= gen_last;
      out_idx_q  <= p1_inside ? p1_idx[IndexW-1:0] : '0;
      out_in_q   <= p1_inside;
      out_r_q    <= p1_r_q;
      out_g_q    <= p1_g_q;
      out_b_q    <= p1_b_q;
      out_last_q <= p1_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'b0, out_in_q, out_r_q, out_g_q, out_b_q, out_idx_q};

endmodule

>>> rtl/core/agpw_checker.sv
module agpw_checker import agpw_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TdataOutW-1:0] m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // off-frame writes carry a zero index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[23:0] == 24'd0)
    else $error("off-frame write with nonzero index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
    else $error("pad bits not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration request refused");

endmodule

bind aces_gamma_pixel_writer_core agpw_checker u_agpw_checker (.*);

>>> tb/aces_gamma_pixel_writer_core_test.sv
`timescale 1ns / 100ps

module aces_gamma_pixel_writer_core_test;
  import agpw_pkg::*;

  localparam int DrainCycles = 45;

  typedef struct {
    logic [23:0] pixel_index;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        in_frame;
    logic        last;
  } fb_write_t;

  typedef struct {
    logic [11:0] column;
    logic [11:0] row;
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] blue;
    bit          typed;
    logic [23:0] idx;
    logic [7:0]  byte_b;
    logic [7:0]  byte_g;
    logic [7:0]  byte_r;
    logic        on_frame;
  } pixel_row_t;

  typedef struct {
    int w;
    int h;
    int s;
    int n;
  } phase_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TdataInW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TdataOutW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  fb_write_t pending_writes[$];
  int        mismatches;
  int        out_stall;
  bit        calm;
  logic [12:0] frame_w;
  logic [12:0] frame_h;
  logic [3:0]  block_side;

  aces_gamma_pixel_writer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #2ms;
    $display("aces_gamma_pixel_writer_core_test NOT OK");
    $finish;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // largest v with v^11 * 2^80 <= t^5 * 255^11
  function automatic logic [7:0] gamma_encode(logic [16:0] t);
    logic [199:0] lim;
    logic [199:0] pw;
    int lo;
    int hi;
    int mid;
    lim = 200'd1;
    for (int k = 0; k < 5; k++) lim = lim * 200'(t);
    for (int k = 0; k < 11; k++) lim = lim * 200'd255;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      pw = 200'd1;
      for (int k = 0; k < 11; k++) pw = pw * 200'(mid);
      pw = pw << 80;
      if (pw <= lim) lo = mid;
      else hi = mid - 1;
    end
    return 8'(lo);
  endfunction

  function automatic logic [7:0] tone_map(logic [23:0] raw);
    bit [63:0] lin;
    bit [63:0] num;
    bit [63:0] den;
    bit [63:0] t;
    if (raw == 24'd0 || raw[23]) return 8'd0;
    lin = (64'(raw) * 64'd256) / 64'd255;
    if (lin > 64'd524288) lin = 64'd524288;
    num = lin * (64'd251 * lin + 64'd196608);
    den = lin * (64'd243 * lin + 64'd3866624) + (64'd14 << 32);
    t = (num * 64'd65536) / den;
    if (t > 64'd65536) t = 64'd65536;
    return gamma_encode(17'(t));
  endfunction

  task automatic expand_block(pixel_row_t p);
    fb_write_t w;
    int side;
    longint ry;
    longint cx;
    side = (block_side > 4'd8) ? 8 : int'(block_side);
    w.red = tone_map(p.red);
    w.green = tone_map(p.green);
    w.blue = tone_map(p.blue);
    for (int i = 0; i < side; i++) begin
      for (int j = 0; j < side; j++) begin
        ry = longint'(frame_h) - 1 - longint'(p.row) - j;
        cx = longint'(p.column) + i;
        w.in_frame = (ry >= 0) && (cx < longint'(frame_w));
        w.pixel_index = w.in_frame ? 24'(ry * longint'(frame_w) + cx) : 24'd0;
        w.last = (i == side - 1) && (j == side - 1);
        pending_writes.push_back(w);
      end
    end
  endtask

  task automatic send_pixel(pixel_row_t p);
    fb_write_t w;
    int gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.blue, p.green, p.red, p.row, p.column};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (p.typed) begin
      w.pixel_index = p.idx;
      w.blue = p.byte_b;
      w.green = p.byte_g;
      w.red = p.byte_r;
      w.in_frame = p.on_frame;
      w.last = 1'b1;
      pending_writes.push_back(w);
    end else begin
      expand_block(p);
    end
  endtask

  task automatic write_reg(cfg_reg_e which, logic [12:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= which;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (which)
      CfgFrameWidth: begin
        frame_w = value;
      end
      CfgFrameHeight: begin
        frame_h = value;
      end
      default: begin
        block_side = value[3:0];
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold until every write has come back, then let a dropped pixel clear out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_channel();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'($urandom_range(1, 255));
      2: return 24'($urandom_range(1, 24'h20000));
      3: return 24'($urandom) | 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] rand_coord(int lim);
    int top;
    if ($urandom_range(0, 4) == 0) return 12'($urandom);
    top = lim + 2;
    if (top > 4095) top = 4095;
    return 12'($urandom_range(0, top));
  endfunction

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      m_axis_tready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fb_write_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_stall = draw_wait();
      if (pending_writes.size() == 0) begin
        $error("unexpected write, index %0d", m_axis_tdata[23:0]);
        mismatches++;
      end else begin
        w = pending_writes.pop_front();
        if (m_axis_tdata[23:0] !== w.pixel_index) begin
          $error("pixel_index exp %0d got %0d", w.pixel_index, m_axis_tdata[23:0]);
          mismatches++;
        end
        if (m_axis_tdata[31:24] !== w.blue) begin
          $error("blue_out exp %0d got %0d", w.blue, m_axis_tdata[31:24]);
          mismatches++;
        end
        if (m_axis_tdata[39:32] !== w.green) begin
          $error("green_out exp %0d got %0d", w.green, m_axis_tdata[39:32]);
          mismatches++;
        end
        if (m_axis_tdata[47:40] !== w.red) begin
          $error("red_out exp %0d got %0d", w.red, m_axis_tdata[47:40]);
          mismatches++;
        end
        if (m_axis_tdata[48] !== w.in_frame) begin
          $error("in_frame exp %0d got %0d", w.in_frame, m_axis_tdata[48]);
          mismatches++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last exp %0d got %0d", w.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pixel_row_t directed_rows[12];
    phase_t     phases[12];
    pixel_row_t p;
    directed_rows = '{
      '{12'd0, 12'd0, 24'd0, 24'd0, 24'd0, 1, 24'd306560, 8'd0, 8'd0, 8'd0, 1'b1},
      '{12'd639, 12'd479, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 24'd639,
        8'd0, 8'd0, 8'd0, 1'b1},
      '{12'd640, 12'd0, 24'd0, 24'd0, 24'd0, 1, 24'd0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd0, 12'd480, 24'd0, 24'd0, 24'd0, 1, 24'd0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd4095, 12'd4095, 24'h800000, 24'h800000, 24'h800000, 1, 24'd0,
        8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd1, 12'd1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 24'd305921,
        8'd255, 8'd255, 8'd255, 1'b1},
      '{12'd5, 12'd7, 24'd1, 24'd2, 24'd255, 0, 24'd0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd100, 12'd200, 24'd65280, 24'd32640, 24'd130560, 0, 24'd0,
        8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd320, 12'd240, 24'd1860000, 24'd500000, 24'd8000, 0, 24'd0,
        8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd639, 12'd0, 24'h7FFFFF, 24'd0, 24'h800001, 0, 24'd0,
        8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd2048, 12'd2048, 24'h0AAAAA, 24'h055555, 24'h000F0F, 0, 24'd0,
        8'd0, 8'd0, 8'd0, 1'b0},
      '{12'd638, 12'd478, 24'd12345, 24'd777, 24'd98765, 0, 24'd0,
        8'd0, 8'd0, 8'd0, 1'b0}
    };
    phases = '{
      '{640, 480, 1, 30}, '{1, 1, 2, 6}, '{4096, 4096, 1, 30}, '{8191, 8191, 3, 8},
      '{0, 5, 2, 4}, '{17, 9, 15, 3}, '{33, 20, 0, 6}, '{100, 50, 4, 20},
      '{4096, 1, 8, 3}, '{13, 4095, 1, 40}, '{640, 480, 5, 10}, '{8, 6, 1, 12}
    };
    mismatches = 0;
    out_stall = 0;
    calm = 1'b0;
    frame_w = 13'd640;
    frame_h = 13'd480;
    block_side = 4'd1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = CfgFrameWidth;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) send_pixel(directed_rows[k]);
    drain();

    foreach (phases[ph]) begin
      write_reg(CfgFrameWidth, 13'(phases[ph].w));
      write_reg(CfgFrameHeight, 13'(phases[ph].h));
      write_reg(CfgScaleFactor, 13'(phases[ph].s));
      calm = (ph % 4 == 2);
      for (int n = 0; n < phases[ph].n; n++) begin
        p.column = rand_coord(phases[ph].w);
        p.row = rand_coord(phases[ph].h);
        p.red = rand_channel();
        p.green = rand_channel();
        p.blue = rand_channel();
        p.typed = 0;
        send_pixel(p);
      end
      drain();
    end

    if (pending_writes.size() != 0) begin
      $error("%0d writes never arrived", pending_writes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("aces_gamma_pixel_writer_core_test OK");
    end else begin
      $display("aces_gamma_pixel_writer_core_test NOT OK");
    end
    $finish;
  end

endmodule
